### src/bpgv_pkg.sv
`default_nettype none

package bpgv_pkg;

  // Widest bit stream held at once: a five-byte varint.
  localparam int SRC_W = 40;
  // Bit counter width: holds up to SRC_W.
  localparam int REM_W = 6;
  // value (32 bits) and bit_count (6 bits), padded to whole bytes.
  localparam int IN_DATA_W = 40;

  typedef enum logic [2:0] {
    REQ_RAW    = 3'd0,
    REQ_REPEAT = 3'd1,
    REQ_VARINT = 3'd2,
    REQ_GAMMA  = 3'd3,
    REQ_FLUSH  = 3'd4,
    REQ_RSVD5  = 3'd5,
    REQ_RSVD6  = 3'd6,
    REQ_RSVD7  = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    SRC_LSB,
    SRC_MSB,
    SRC_REPEAT,
    SRC_ZERO
  } src_mode_t;

  typedef struct packed {
    src_mode_t        mode;
    logic [7:0]       pending;
    logic [2:0]       fill;
    logic [REM_W-1:0] rem;
  } pack_ctl_t;

  typedef struct packed {
    logic             byte_done;
    logic [7:0]       done_byte;
    logic [7:0]       pending;
    logic [2:0]       fill;
    logic [SRC_W-1:0] src;
    logic [REM_W-1:0] rem;
  } pack_res_t;

endpackage

`default_nettype wire

### src/bpgv_pack_unit.sv
`default_nettype none

module bpgv_pack_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  bpgv_pkg::pack_ctl_t             ctl,
  input  logic [bpgv_pkg::SRC_W-1:0]      src,
  output bpgv_pkg::pack_res_t             res
);
  import bpgv_pkg::*;

  logic [3:0]  room;
  logic [3:0]  take;
  logic [7:0]  chunk;
  logic [7:0]  mask;
  logic [15:0] merged;
  logic [3:0]  fill_sum;

  always_comb begin
    room = 4'd8 - {1'b0, ctl.fill};
    take = (ctl.rem < REM_W'(room)) ? ctl.rem[3:0] : room;

    case (ctl.mode)
      SRC_LSB: chunk = src[7:0];
      SRC_MSB: begin
        // take the top bits of the value word, most significant first
        for (int j = 0; j < 8; j++) begin
          chunk[j] = src[VALUE_WIDTH-1-j];
        end
      end
      SRC_REPEAT: chunk = {8{src[0]}};
      default: chunk = 8'h00;
    endcase

    mask     = 8'((9'd1 << take) - 9'd1);
    merged   = {8'h00, ctl.pending} | ({8'h00, chunk & mask} << ctl.fill);
    fill_sum = {1'b0, ctl.fill} + take;

    res.byte_done = fill_sum[3];
    res.done_byte = merged[7:0];
    res.pending   = fill_sum[3] ? 8'h00 : merged[7:0];
    res.fill      = fill_sum[2:0];
    res.rem       = ctl.rem - REM_W'(take);

    res.src = src;
    case (ctl.mode)
      SRC_LSB: res.src = src >> take;
      SRC_MSB: res.src[VALUE_WIDTH-1:0] = src[VALUE_WIDTH-1:0] << take;
      default: res.src = src;
    endcase
  end

endmodule

`default_nettype wire

### src/bitstream_packer_gamma_varint.sv
`default_nettype none

// Bit packer with raw, repeat, varint and Elias gamma requests. Bits are
// packed least significant first; every completed byte leaves on the out
// channel, and out_tlast marks the final byte a request causes. A flush
// request sends the pending byte (zero when empty) with out_tlast set and
// clears it. One request at a time: the input takes no new transaction
// until the current one is packed. A shared unit merges up to eight bits per
// cycle while the output is not stalled, as many as fit in the pending byte.
// Gamma first finds the code length (eight-bit then one-bit normalizing
// shifts), then packs up to 63 bits. A stalled output slot holds the
// packing and the final byte.
module bitstream_packer_gamma_varint #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bpgv_pkg::IN_DATA_W-1:0] in_tdata,  // value[31:0], bit_count[37:32]
  input  logic [2:0]                    in_tuser,   // req_type[2:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // out_byte[7:0]
  output logic                          out_tlast
);
  import bpgv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM8,
    ST_NORM1,
    ST_ZRUN,
    ST_PACK,
    ST_FINISH,
    ST_FLUSH
  } state_t;

  state_t           state_r,   state_nxt;
  src_mode_t        mode_r,    mode_nxt;
  logic [7:0]       pend_r,    pend_nxt;
  logic [2:0]       fill_r,    fill_nxt;
  logic [SRC_W-1:0] src_r,     src_nxt;
  logic [REM_W-1:0] rem_r,     rem_nxt;
  logic [REM_W-1:0] lz_r,      lz_nxt;
  logic [7:0]       hold_r,    hold_nxt;
  logic             hold_v_r,  hold_v_nxt;
  logic             out_v_r,   out_v_nxt;
  logic [7:0]       out_d_r,   out_d_nxt;
  logic             out_l_r,   out_l_nxt;

  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] gamma_code;
  logic [63:0]            val64;
  logic [5:0]             cnt;
  logic [REM_W-1:0]       cnt_c;
  logic [3:0]             vi_more;
  logic [2:0]             vi_nb;
  logic [SRC_W-1:0]       vi_strm;
  logic                   in_acc;
  logic                   out_free;
  logic                   stall;
  pack_ctl_t              pk_ctl;
  pack_res_t              pk_res;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_v_r || out_tready;

  assign val        = in_tdata[VALUE_WIDTH-1:0];
  assign val64      = 64'(val);
  assign gamma_code = (&val) ? val : (val + VALUE_WIDTH'(1));
  assign cnt        = in_tdata[37:32];
  assign cnt_c      = (cnt > REM_W'(VALUE_WIDTH)) ? REM_W'(VALUE_WIDTH) : cnt;

  // varint bytes: seven value bits each, continuation while higher bits remain
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      vi_more[i]         = (val64 >> (7 * (i + 1))) != 64'd0;
      vi_strm[8*i +: 7]  = val64[7*i +: 7];
      vi_strm[8*i + 7]   = vi_more[i];
    end
    vi_strm[39:32] = val64[35:28];
    vi_nb = 3'd1 + 3'(vi_more[0]) + 3'(vi_more[1]) + 3'(vi_more[2]) + 3'(vi_more[3]);
  end

  assign pk_ctl.mode    = mode_r;
  assign pk_ctl.pending = pend_r;
  assign pk_ctl.fill    = fill_r;
  assign pk_ctl.rem     = rem_r;

  bpgv_pack_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_pack (
    .ctl(pk_ctl),
    .src(src_r),
    .res(pk_res)
  );

  // hold a finished byte until we know whether it ends the request
  assign stall = pk_res.byte_done && hold_v_r && !out_free;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    fill_nxt   = fill_r;
    src_nxt    = src_r;
    rem_nxt    = rem_r;
    lz_nxt     = lz_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_d_nxt  = out_d_r;
    out_l_nxt  = out_l_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_RAW: begin
              mode_nxt  = SRC_LSB;
              src_nxt   = val64[SRC_W-1:0];
              rem_nxt   = cnt_c;
              state_nxt = ST_PACK;
            end
            REQ_REPEAT: begin
              mode_nxt  = SRC_REPEAT;
              src_nxt   = val64[SRC_W-1:0];
              rem_nxt   = cnt_c;
              state_nxt = ST_PACK;
            end
            REQ_VARINT: begin
              mode_nxt  = SRC_LSB;
              src_nxt   = vi_strm;
              rem_nxt   = {vi_nb, 3'b000};
              state_nxt = ST_PACK;
            end
            REQ_GAMMA: begin
              mode_nxt  = SRC_ZERO;
              src_nxt   = SRC_W'(gamma_code);
              lz_nxt    = '0;
              state_nxt = ST_NORM8;
            end
            REQ_FLUSH: state_nxt = ST_FLUSH;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_NORM8: begin
        if (src_r[VALUE_WIDTH-1 -: 8] == 8'h00) begin
          src_nxt[VALUE_WIDTH-1:0] = src_r[VALUE_WIDTH-1:0] << 8;
          lz_nxt = lz_r + REM_W'(8);
        end else begin
          state_nxt = ST_NORM1;
        end
      end

      ST_NORM1: begin
        if (!src_r[VALUE_WIDTH-1]) begin
          src_nxt[VALUE_WIDTH-1:0] = src_r[VALUE_WIDTH-1:0] << 1;
          lz_nxt = lz_r + REM_W'(1);
        end else begin
          // n-1 leading zeros, n = code length
          rem_nxt   = REM_W'(VALUE_WIDTH - 1) - lz_r;
          mode_nxt  = SRC_ZERO;
          state_nxt = ST_ZRUN;
        end
      end

      ST_ZRUN, ST_PACK: begin
        if (!stall) begin
          pend_nxt = pk_res.pending;
          fill_nxt = pk_res.fill;
          src_nxt  = pk_res.src;
          rem_nxt  = pk_res.rem;
          if (pk_res.byte_done) begin
            if (hold_v_r) begin
              out_v_nxt = 1'b1;
              out_d_nxt = hold_r;
              out_l_nxt = 1'b0;
            end
            hold_nxt   = pk_res.done_byte;
            hold_v_nxt = 1'b1;
          end
          if (pk_res.rem == '0) begin
            if (state_r == ST_ZRUN) begin
              mode_nxt  = SRC_MSB;
              rem_nxt   = REM_W'(VALUE_WIDTH) - lz_r;
              state_nxt = ST_PACK;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt  = 1'b1;
          out_d_nxt  = hold_r;
          out_l_nxt  = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = pend_r;
          out_l_nxt = 1'b1;
          pend_nxt  = 8'h00;
          fill_nxt  = 3'd0;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_r   <= 8'h00;
      fill_r   <= 3'd0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      fill_r   <= fill_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    mode_r  <= mode_nxt;
    src_r   <= src_nxt;
    rem_r   <= rem_nxt;
    lz_r    <= lz_nxt;
    hold_r  <= hold_nxt;
    out_d_r <= out_d_nxt;
    out_l_r <= out_l_nxt;
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_v_r)
    else $error("held byte left behind at end of request");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM8 || state_r == ST_NORM1) |-> (src_r[VALUE_WIDTH-1:0] != '0))
    else $error("gamma code is zero during normalization");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PACK || state_r == ST_ZRUN) |-> (rem_r <= REM_W'(SRC_W)))
    else $error("bit count beyond stream width");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (out_v_r && out_l_r && fill_r == 3'd0))
    else $error("flush did not emit a final byte");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

localparam logic [31:0] VARINT_HIGH = 32'hFFFFFF80;
localparam logic [31:0] VARINT_LOW  = 32'h0000007F;
localparam logic [31:0] VARINT_CONT = 32'h00000080;

class packer_scoreboard;
  logic [7:0]  pend;
  int unsigned fill;
  logic [7:0]  item_bytes[$];
  logic [7:0]  byte_q[$];
  logic        last_q[$];
  int unsigned errors;
  int unsigned n_reqs;
  int unsigned n_bytes;
  int unsigned n_flushes;

  function new();
    pend = '0;
    fill = 0;
    errors = 0;
    n_reqs = 0;
    n_bytes = 0;
    n_flushes = 0;
  endfunction

  function void push_bit(logic b);
    pend[fill] = b;
    fill++;
    if (fill == 8) begin
      item_bytes.push_back(pend);
      pend = '0;
      fill = 0;
    end
  endfunction

  function void push_lsb(logic [31:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_bit(v[i]);
  endfunction

  // Predict the bytes one accepted request produces and queue them.
  function void note_request(bpgv_pkg::req_type_t t, logic [31:0] v, logic [5:0] cnt);
    int unsigned n;
    int unsigned len;
    logic [31:0] code;
    bit          done;
    item_bytes = {};
    n = (cnt > 32) ? 32 : cnt;
    done = 0;
    n_reqs++;
    case (t)
      bpgv_pkg::REQ_RAW: begin
        push_lsb(v, n);
      end
      bpgv_pkg::REQ_REPEAT: begin
        repeat (n) push_bit(v[0]);
      end
      bpgv_pkg::REQ_VARINT: begin
        for (int i = 0; i < 5 && !done; i++) begin
          // the fifth group keeps all remaining high bits, no continuation
          if ((v & VARINT_HIGH) == 0 || i == 4) begin
            push_lsb(v & 32'hFF, 8);
            done = 1;
          end else begin
            push_lsb((v & VARINT_LOW) | VARINT_CONT, 8);
            v = v >> 7;
          end
        end
      end
      bpgv_pkg::REQ_GAMMA: begin
        if (v == '1) v = v - 1;
        code = v + 1;
        len = 0;
        while (len < 32 && (code >> len) != 0) len++;
        repeat (len - 1) push_bit(1'b0);
        for (int i = len; i > 0; i--) push_bit(code[i-1]);
      end
      bpgv_pkg::REQ_FLUSH: begin
        item_bytes.push_back(pend);
        pend = '0;
        fill = 0;
        n_flushes++;
      end
      default: ;
    endcase
    foreach (item_bytes[i]) begin
      byte_q.push_back(item_bytes[i]);
      last_q.push_back(i == item_bytes.size() - 1);
    end
  endfunction

  function void check_byte(logic [7:0] got_byte, logic got_last);
    logic [7:0] exp_byte;
    logic       exp_last;
    if (byte_q.size() == 0) begin
      $error("unexpected transaction: out_byte %02h last %0b", got_byte, got_last);
      errors++;
      return;
    end
    exp_byte = byte_q.pop_front();
    exp_last = last_q.pop_front();
    n_bytes++;
    if (got_byte !== exp_byte) begin
      $error("out_byte: expected %02h, actual %02h", exp_byte, got_byte);
      errors++;
    end
    if (got_last !== exp_last) begin
      $error("last: expected %0b, actual %0b", exp_last, got_last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import bpgv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 400;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [2:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tlast;

  packer_scoreboard sb;
  int unsigned      send_idle;
  int unsigned      recv_idle;
  int unsigned      stall_reqs = 0;
  int unsigned      stall_seen = 0;
  int unsigned      stall_left = 0;
  int unsigned      cycles = 0;

  bitstream_packer_gamma_varint #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: check each transaction, then pick next cycle's ready.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
      // start a long hold-off when the sender asks for one
      if (stall_seen != stall_reqs) begin
        stall_seen = stall_reqs;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(req_type_t t, logic [31:0] v, logic [5:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= t;
    in_tdata  <= {2'b00, cnt, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(t, v, cnt);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.byte_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int unsigned num);
    int unsigned sent;
    int unsigned pick;
    logic [31:0] v;
    logic [5:0]  cnt;
    sent = 0;
    while (sent < num) begin
      pick = $urandom_range(99);
      v = $urandom;
      cnt = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
      if (pick < 25) begin
        send_item(REQ_RAW, v, cnt);
      end else if (pick < 40) begin
        send_item(REQ_REPEAT, v, cnt);
      end else if (pick < 62) begin
        if ($urandom_range(9) == 0) v = '1;
        else v = v >> $urandom_range(31);
        send_item(REQ_VARINT, v, cnt);
      end else if (pick < 88) begin
        if ($urandom_range(9) == 0) v = '1;
        else v = v >> $urandom_range(31);
        send_item(REQ_GAMMA, v, cnt);
      end else if (pick < 96) begin
        send_item(REQ_FLUSH, v, cnt);
      end else begin
        // ignored by the block: not counted
        send_item(req_type_t'(3'($urandom_range(5, 7))), v, cnt);
        continue;
      end
      sent++;
    end
  endtask

  initial begin
    sb = new();
    send_idle = 17;
    recv_idle = 45;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(REQ_RAW, 32'hFFFFFFFF, 6'd32);
    send_item(REQ_RAW, 32'h00000000, 6'd0);
    send_item(REQ_RAW, 32'hA5A55A5A, 6'd63);
    send_item(REQ_RAW, 32'h00000005, 6'd3);
    send_item(REQ_FLUSH, 32'h00000000, 6'd0);
    send_item(REQ_FLUSH, 32'hFFFFFFFF, 6'd63);
    send_item(REQ_REPEAT, 32'h00000001, 6'd40);
    send_item(REQ_REPEAT, 32'h00000000, 6'd0);
    send_item(REQ_REPEAT, 32'hFFFFFFFE, 6'd13);
    send_item(REQ_VARINT, 32'h00000000, 6'd0);
    send_item(REQ_VARINT, 32'h0000007F, 6'd0);
    send_item(REQ_VARINT, 32'h00000080, 6'd0);
    send_item(REQ_VARINT, 32'h0FFFFFFF, 6'd0);
    send_item(REQ_VARINT, 32'hFFFFFFFF, 6'd0);
    send_item(REQ_GAMMA, 32'h00000000, 6'd0);
    send_item(REQ_GAMMA, 32'h00000001, 6'd0);
    send_item(REQ_GAMMA, 32'hFFFFFFFE, 6'd0);
    send_item(REQ_GAMMA, 32'hFFFFFFFF, 6'd0);
    send_item(REQ_GAMMA, 32'h7FFFFFFF, 6'd0);
    send_item(REQ_RSVD5, 32'h12345678, 6'd8);
    send_item(REQ_RSVD6, 32'hFFFFFFFF, 6'd63);
    send_item(REQ_RSVD7, 32'h00000000, 6'd0);
    send_item(REQ_FLUSH, 32'h00000000, 6'd0);
    wait_drained();

    send_random(110);
    wait_drained();

    send_idle = 45;
    recv_idle = 17;
    send_random(110);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    // hold the output off so the packer backs up into its input
    stall_reqs = stall_reqs + 1;
    send_random(30);
    wait_drained();
    send_random(80);
    wait_drained();

    repeat (40) @(posedge clk);
    if (sb.byte_q.size() != 0) begin
      $error("%0d expected bytes never arrived", sb.byte_q.size());
      sb.errors++;
    end
    $display("summary: %0d requests (raw, repeat, varint, gamma, flush, ignored types)",
             sb.n_reqs);
    $display("summary: %0d bytes checked, %0d flushes, %0d errors",
             sb.n_bytes, sb.n_flushes, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
